@@ rtl/core/intel_hex_record_loader_top_defines.svh @@
// ----------------------------------------------------------------------------
// Intel HEX record loader assertion macros
// Concurrent assertion shorthands on clk with rst as the disable condition.
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_LOADER_TOP_DEFINES_SVH
`define INTEL_HEX_RECORD_LOADER_TOP_DEFINES_SVH

// same-cycle implication
`define IHEX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IHEX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ihex_pkg.sv @@
// ----------------------------------------------------------------------------
// Intel HEX record loader package
// Shared types, character codes, event codes and the character classifier.
// ----------------------------------------------------------------------------
package ihex_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int OFFSET_W    = 16;
  localparam int BANK_W      = 3;
  localparam int ADDR_W      = BANK_W + OFFSET_W;
  localparam int COUNT_W     = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_REMAP_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REMAP_OFFSET    = 1'd1;

  localparam logic [OFFSET_W-1:0] REMAP_THRESHOLD_RST = 16'hA000;
  localparam logic [OFFSET_W-1:0] REMAP_OFFSET_RST    = 16'h7F00;

  localparam logic [15:0]       BANK_LO      = 16'h00FB;
  localparam logic [15:0]       BANK_HI      = 16'h00FE;
  localparam logic [15:0]       BANK_BASE    = 16'h00FA;
  localparam logic [BANK_W-1:0] BANK_DEFAULT = 3'd1;

  localparam logic [7:0] CHAR_ESC     = 8'd27;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_0       = 8'h30;
  localparam logic [7:0] CHAR_9       = 8'h39;
  localparam logic [7:0] CHAR_UC_A    = 8'h41;
  localparam logic [7:0] CHAR_UC_F    = 8'h46;
  localparam logic [7:0] CHAR_LC_A    = 8'h61;
  localparam logic [7:0] CHAR_LC_F    = 8'h66;
  localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_EXT_LIN = 8'h04;

  typedef enum logic [2:0] {
    CLS_HEX     = 3'd0,
    CLS_COLON   = 3'd1,
    CLS_NEWLINE = 3'd2,
    CLS_ESC     = 3'd3,
    CLS_OTHER   = 3'd4
  } char_cls_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_BYTE   = 3'd1,
    EV_GOOD   = 3'd2,
    EV_CKSUM  = 3'd3,
    EV_RTYPE  = 3'd4,
    EV_STRAY  = 3'd5,
    EV_NONHEX = 3'd6,
    EV_ENDED  = 3'd7
  } event_t;

  typedef struct packed {
    char_cls_t  cls;
    logic [3:0] nib;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic q_entry_t classify(input logic [7:0] c);
    q_entry_t e;
    e.cls = CLS_OTHER;
    e.nib = 4'd0;
    if (c inside {[CHAR_0:CHAR_9]}) begin
      e.cls = CLS_HEX;
      e.nib = 4'(c - CHAR_0);
    end else if (c inside {[CHAR_UC_A:CHAR_UC_F]}) begin
      e.cls = CLS_HEX;
      e.nib = 4'(c - CHAR_UC_A + HEX_LETTER_BASE);
    end else if (c inside {[CHAR_LC_A:CHAR_LC_F]}) begin
      e.cls = CLS_HEX;
      e.nib = 4'(c - CHAR_LC_A + HEX_LETTER_BASE);
    end else if (c == CHAR_COLON) begin
      e.cls = CLS_COLON;
    end else if (c == CHAR_NEWLINE) begin
      e.cls = CLS_NEWLINE;
    end else if (c == CHAR_ESC) begin
      e.cls = CLS_ESC;
    end
    return e;
  endfunction

endpackage

@@ rtl/core/ihex_front.sv @@
// ----------------------------------------------------------------------------
// Intel HEX loader front end
// Accepts received characters, classifies them and pushes them to the queue.
// ----------------------------------------------------------------------------
module ihex_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_char,
  input  ihex_pkg::q_status_t  q_status,
  output logic                 push,
  output ihex_pkg::q_entry_t   push_entry
);

  assign in_stall   = q_status.full;
  assign push       = in_valid && !q_status.full;
  assign push_entry = ihex_pkg::classify(rx_char);

endmodule

@@ rtl/core/ihex_queue.sv @@
// ----------------------------------------------------------------------------
// Intel HEX loader item queue
// Short register queue between the front end and the record parser.
// ----------------------------------------------------------------------------
module ihex_queue #(
  parameter int DEPTH = ihex_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ihex_pkg::q_entry_t  push_entry,
  input  logic                pop,
  output ihex_pkg::q_entry_t  head,
  output ihex_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ihex_pkg::q_entry_t store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] level;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  assign head         = store[rd_ptr];
  assign status.full  = (level == CNT_FULL);
  assign status.empty = (level == '0);

endmodule

@@ rtl/core/ihex_back.sv @@
// ----------------------------------------------------------------------------
// Intel HEX loader record parser
// Pairs digits into bytes, walks the record fields and registers each result.
// ----------------------------------------------------------------------------
module ihex_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  input  logic [ihex_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [ihex_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  ihex_pkg::q_status_t                     q_status,
  input  ihex_pkg::q_entry_t                      head,
  output logic                                    pop,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    write_valid,
  output logic [ihex_pkg::ADDR_W-1:0]             write_addr,
  output logic [7:0]                              write_data,
  output logic [2:0]                              event_res,
  output logic [ihex_pkg::COUNT_W-1:0]            line_count,
  output logic [ihex_pkg::COUNT_W-1:0]            byte_count,
  output logic [ihex_pkg::COUNT_W-1:0]            good_record_count,
  output logic [ihex_pkg::COUNT_W-1:0]            checksum_error_count,
  output logic [ihex_pkg::COUNT_W-1:0]            rectype_error_count,
  output logic [ihex_pkg::COUNT_W-1:0]            nonhex_count,
  output logic [ihex_pkg::COUNT_W-1:0]            stray_colon_count,
  output logic [ihex_pkg::ADDR_W-1:0]             highest_addr,
  output logic                                    done
);

  typedef enum logic [9:0] {
    PH_IDLE   = 10'b0000000001,
    PH_LEN    = 10'b0000000010,
    PH_OFFH   = 10'b0000000100,
    PH_OFFL   = 10'b0000001000,
    PH_TYPE   = 10'b0000010000,
    PH_DATA   = 10'b0000100000,
    PH_EXTH   = 10'b0001000000,
    PH_EXTL   = 10'b0010000000,
    PH_CHK    = 10'b0100000000,
    PH_EOFCHK = 10'b1000000000
  } phase_t;

  localparam int CW = ihex_pkg::COUNT_W;
  localparam int OW = ihex_pkg::OFFSET_W;
  localparam int BW = ihex_pkg::BANK_W;
  localparam int AW = ihex_pkg::ADDR_W;

  logic [OW-1:0] remap_threshold;
  logic [OW-1:0] remap_offset;

  phase_t        phase, phase_next;
  logic          pending, pending_next;
  logic [3:0]    high_nibble, high_nibble_next;
  logic [7:0]    running_sum, running_sum_next;
  logic [7:0]    bytes_left, bytes_left_next;
  logic [7:0]    offset_high, offset_high_next;
  logic [7:0]    ext_high, ext_high_next;
  logic [BW-1:0] bank, bank_next;
  logic [OW-1:0] load_offset, load_offset_next;
  logic          done_next;

  logic [CW-1:0] line_count_next, byte_count_next, good_record_count_next;
  logic [CW-1:0] checksum_error_count_next, rectype_error_count_next;
  logic [CW-1:0] nonhex_count_next, stray_colon_count_next;
  logic [AW-1:0] highest_addr_next;

  logic              wv_next;
  logic [AW-1:0]     wa_next;
  logic [7:0]        wd_next;
  ihex_pkg::event_t  ev_next;

  logic [7:0]    cur_byte;
  logic [7:0]    sum_new;
  logic [15:0]   ext_val;
  logic [AW-1:0] full_addr;
  logic [OW-1:0] mapped_off;
  logic          rec_ok;

  assign pop = !q_status.empty && (!out_valid || !out_stall);

  assign cur_byte   = {high_nibble, head.nib};
  assign sum_new    = running_sum + cur_byte;
  assign ext_val    = {ext_high, cur_byte};
  assign full_addr  = {bank, load_offset};
  assign mapped_off = (load_offset >= remap_threshold) ? load_offset - remap_offset
                                                       : load_offset;
  assign rec_ok     = (sum_new == 8'd0) && (bytes_left == 8'd0);

  always_comb begin
    phase_next                = phase;
    pending_next              = pending;
    high_nibble_next          = high_nibble;
    running_sum_next          = running_sum;
    bytes_left_next           = bytes_left;
    offset_high_next          = offset_high;
    ext_high_next             = ext_high;
    bank_next                 = bank;
    load_offset_next          = load_offset;
    done_next                 = done;
    line_count_next           = line_count;
    byte_count_next           = byte_count;
    good_record_count_next    = good_record_count;
    checksum_error_count_next = checksum_error_count;
    rectype_error_count_next  = rectype_error_count;
    nonhex_count_next         = nonhex_count;
    stray_colon_count_next    = stray_colon_count;
    highest_addr_next         = highest_addr;
    wv_next                   = 1'b0;
    wa_next                   = '0;
    wd_next                   = 8'd0;
    ev_next                   = ihex_pkg::EV_NONE;

    if (pop && !done) begin
      if (head.cls == ihex_pkg::CLS_ESC) begin
        done_next = 1'b1;
        ev_next   = ihex_pkg::EV_ENDED;
      end else if (phase == PH_IDLE) begin
        if (head.cls == ihex_pkg::CLS_COLON) begin
          line_count_next  = line_count + 1'b1;
          running_sum_next = 8'd0;
          pending_next     = 1'b0;
          phase_next       = PH_LEN;
        end else if (head.cls == ihex_pkg::CLS_OTHER) begin
          nonhex_count_next = nonhex_count + 1'b1;
          ev_next           = ihex_pkg::EV_NONHEX;
        end
      end else if (head.cls == ihex_pkg::CLS_COLON) begin
        stray_colon_count_next = stray_colon_count + 1'b1;
        running_sum_next       = 8'd0;
        pending_next           = 1'b0;
        phase_next             = PH_LEN;
        ev_next                = ihex_pkg::EV_STRAY;
      end else if (head.cls == ihex_pkg::CLS_NEWLINE) begin
        checksum_error_count_next = checksum_error_count + 1'b1;
        pending_next              = 1'b0;
        phase_next                = PH_IDLE;
        ev_next                   = ihex_pkg::EV_CKSUM;
      end else if (head.cls != ihex_pkg::CLS_HEX) begin
        nonhex_count_next = nonhex_count + 1'b1;
        ev_next           = ihex_pkg::EV_NONHEX;
      end else if (!pending) begin
        high_nibble_next = head.nib;
        pending_next     = 1'b1;
      end else begin
        pending_next     = 1'b0;
        running_sum_next = sum_new;
        case (phase)
          PH_LEN: begin
            bytes_left_next = cur_byte;
            phase_next      = PH_OFFH;
          end
          PH_OFFH: begin
            offset_high_next = cur_byte;
            phase_next       = PH_OFFL;
          end
          PH_OFFL: begin
            load_offset_next = {offset_high, cur_byte};
            phase_next       = PH_TYPE;
          end
          PH_TYPE: begin
            if (cur_byte == ihex_pkg::REC_DATA) begin
              phase_next = (bytes_left == 8'd0) ? PH_CHK : PH_DATA;
            end else if (cur_byte == ihex_pkg::REC_EOF) begin
              phase_next = PH_EOFCHK;
            end else if (cur_byte == ihex_pkg::REC_EXT_LIN) begin
              phase_next = PH_EXTH;
            end else begin
              rectype_error_count_next = rectype_error_count + 1'b1;
              phase_next               = PH_IDLE;
              ev_next                  = ihex_pkg::EV_RTYPE;
            end
          end
          PH_DATA: begin
            if (full_addr > highest_addr) begin
              highest_addr_next = full_addr;
            end
            wv_next          = 1'b1;
            wa_next          = {bank, mapped_off};
            wd_next          = cur_byte;
            ev_next          = ihex_pkg::EV_BYTE;
            byte_count_next  = byte_count + 1'b1;
            load_offset_next = load_offset + 1'b1;
            bytes_left_next  = bytes_left - 8'd1;
            if (bytes_left == 8'd1) begin
              phase_next = PH_CHK;
            end
          end
          PH_EXTH: begin
            ext_high_next   = cur_byte;
            bytes_left_next = bytes_left - 8'd1;
            phase_next      = PH_EXTL;
          end
          PH_EXTL: begin
            bytes_left_next = bytes_left - 8'd1;
            if (ext_val >= ihex_pkg::BANK_LO && ext_val <= ihex_pkg::BANK_HI) begin
              bank_next = BW'(ext_val - ihex_pkg::BANK_BASE);
            end else begin
              bank_next = ihex_pkg::BANK_DEFAULT;
            end
            load_offset_next = '0;
            phase_next       = PH_CHK;
          end
          PH_CHK: begin
            if (rec_ok) begin
              good_record_count_next = good_record_count + 1'b1;
              ev_next                = ihex_pkg::EV_GOOD;
            end else begin
              checksum_error_count_next = checksum_error_count + 1'b1;
              ev_next                   = ihex_pkg::EV_CKSUM;
            end
            phase_next = PH_IDLE;
          end
          PH_EOFCHK: begin
            if (rec_ok) begin
              good_record_count_next = good_record_count + 1'b1;
            end else begin
              checksum_error_count_next = checksum_error_count + 1'b1;
            end
            phase_next = PH_IDLE;
            done_next  = 1'b1;
            ev_next    = ihex_pkg::EV_ENDED;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remap_threshold <= ihex_pkg::REMAP_THRESHOLD_RST;
      remap_offset    <= ihex_pkg::REMAP_OFFSET_RST;
    end else if (cfg_valid) begin
      if (cfg_index == ihex_pkg::CFG_REMAP_THRESHOLD) begin
        remap_threshold <= cfg_data;
      end else if (cfg_index == ihex_pkg::CFG_REMAP_OFFSET) begin
        remap_offset <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_IDLE;
      pending              <= 1'b0;
      high_nibble          <= 4'd0;
      running_sum          <= 8'd0;
      bytes_left           <= 8'd0;
      offset_high          <= 8'd0;
      ext_high             <= 8'd0;
      bank                 <= '0;
      load_offset          <= '0;
      done                 <= 1'b0;
      line_count           <= '0;
      byte_count           <= '0;
      good_record_count    <= '0;
      checksum_error_count <= '0;
      rectype_error_count  <= '0;
      nonhex_count         <= '0;
      stray_colon_count    <= '0;
      highest_addr         <= '0;
      out_valid            <= 1'b0;
    end else begin
      phase                <= phase_next;
      pending              <= pending_next;
      high_nibble          <= high_nibble_next;
      running_sum          <= running_sum_next;
      bytes_left           <= bytes_left_next;
      offset_high          <= offset_high_next;
      ext_high             <= ext_high_next;
      bank                 <= bank_next;
      load_offset          <= load_offset_next;
      done                 <= done_next;
      line_count           <= line_count_next;
      byte_count           <= byte_count_next;
      good_record_count    <= good_record_count_next;
      checksum_error_count <= checksum_error_count_next;
      rectype_error_count  <= rectype_error_count_next;
      nonhex_count         <= nonhex_count_next;
      stray_colon_count    <= stray_colon_count_next;
      highest_addr         <= highest_addr_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      write_valid <= wv_next;
      write_addr  <= wa_next;
      write_data  <= wd_next;
      event_res   <= ev_next;
    end
  end

endmodule

@@ rtl/core/intel_hex_record_loader_top.sv @@
// ----------------------------------------------------------------------------
// Intel HEX record loader top level
// An accepted character is queued, then its result is registered on its pop;
// one character a cycle sustained while out_stall is low, set by the parser.
// Reset (rst, synchronous) clears parser state and counters, empties the queue
// and returns the remap registers to their default values.
// ----------------------------------------------------------------------------
`include "intel_hex_record_loader_top_defines.svh"

module intel_hex_record_loader_top #(
  parameter int QUEUE_DEPTH = ihex_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           rx_char,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 write_valid,
  output logic [ihex_pkg::ADDR_W-1:0]          write_addr,
  output logic [7:0]                           write_data,
  output logic [2:0]                           event_res,
  output logic [ihex_pkg::COUNT_W-1:0]         line_count,
  output logic [ihex_pkg::COUNT_W-1:0]         byte_count,
  output logic [ihex_pkg::COUNT_W-1:0]         good_record_count,
  output logic [ihex_pkg::COUNT_W-1:0]         checksum_error_count,
  output logic [ihex_pkg::COUNT_W-1:0]         rectype_error_count,
  output logic [ihex_pkg::COUNT_W-1:0]         nonhex_count,
  output logic [ihex_pkg::COUNT_W-1:0]         stray_colon_count,
  output logic [ihex_pkg::ADDR_W-1:0]          highest_addr,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ihex_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ihex_pkg::CFG_DATA_W-1:0]      cfg_data
);

  ihex_pkg::q_status_t q_status;
  ihex_pkg::q_entry_t  q_push_entry;
  ihex_pkg::q_entry_t  q_head;
  logic                q_push;
  logic                q_pop;
  logic                parse_done;

  assign cfg_ready = 1'b1;

  ihex_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_char    (rx_char),
    .q_status   (q_status),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  ihex_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  ihex_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .q_status             (q_status),
    .head                 (q_head),
    .pop                  (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .write_valid          (write_valid),
    .write_addr           (write_addr),
    .write_data           (write_data),
    .event_res            (event_res),
    .line_count           (line_count),
    .byte_count           (byte_count),
    .good_record_count    (good_record_count),
    .checksum_error_count (checksum_error_count),
    .rectype_error_count  (rectype_error_count),
    .nonhex_count         (nonhex_count),
    .stray_colon_count    (stray_colon_count),
    .highest_addr         (highest_addr),
    .done                 (parse_done)
  );

  `IHEX_ASSERT_IMP(a_pop_not_empty, q_pop, !q_status.empty, "pop from empty queue")
  `IHEX_ASSERT_IMP(a_push_not_full, q_push, !q_status.full, "push into full queue")
  `IHEX_ASSERT_IMP(a_write_is_byte, out_valid && write_valid, event_res == ihex_pkg::EV_BYTE, "write without byte event")
  `IHEX_ASSERT_NXT(a_done_sticky, parse_done, parse_done, "parse end flag cleared")

endmodule
